[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the saturation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// A condition that implies another one in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// A condition that implies another one in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/rfs_pkg.sv]
// Types and constants shared by the saturation pipeline.
package rfs_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int NUM_CH = 3;

    // Channel positions in the per-channel masks.
    localparam int CH_RED = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE = 2;

    // The divider retires two quotient bits in each stage.
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = (CHANNEL_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
    localparam int DIV_BITS = DIV_STAGES * DIV_STEPS_PER_STAGE;
    localparam int PROD_BITS = 2 * CHANNEL_BITS;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [DIV_BITS-1:0] quo_t;
    typedef logic [PROD_BITS-1:0] prod_t;
    typedef logic [NUM_CH-1:0] chmask_t;

    localparam chan_t FULL_SCALE = '1;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    // Word in flight through the divider stages.
    typedef struct packed {
        logic valid;
        logic flat;
        chmask_t top;
        chmask_t bot;
        chan_t d;
        chan_t rem;
        quo_t low;
        quo_t quo;
    } divst_t;

endpackage

[sv/rfs_channels.sv]
// Handshake channels for input and result pixels.
interface rfs_pixel_in_if;
    logic valid;
    logic ready;
    rfs_pkg::chan_t red_in;
    rfs_pkg::chan_t green_in;
    rfs_pkg::chan_t blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface rfs_pixel_out_if;
    logic valid;
    logic ready;
    rfs_pkg::chan_t red_out;
    rfs_pkg::chan_t green_out;
    rfs_pkg::chan_t blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

[sv/rfs_range.sv]
// Front end: channel range, middle-channel offset and the divider's dividend.
module rfs_range (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic valid,
    input  rfs_pkg::pixel_t pixel,
    output rfs_pkg::divst_t div_out
);

    typedef struct packed {
        logic valid;
        logic flat;
        rfs_pkg::chmask_t top;
        rfs_pkg::chmask_t bot;
        rfs_pkg::chan_t d;
        rfs_pkg::chan_t n;
    } range_t;

    rfs_pkg::chan_t ch [rfs_pkg::NUM_CH];
    rfs_pkg::chan_t mx;
    rfs_pkg::chan_t mn;
    rfs_pkg::chan_t mid_val;
    rfs_pkg::chmask_t edge_mask;
    range_t range_next;
    range_t range_reg;
    rfs_pkg::prod_t fn;
    rfs_pkg::divst_t div_next;
    rfs_pkg::divst_t div_reg;

    assign ch[rfs_pkg::CH_RED] = pixel.red;
    assign ch[rfs_pkg::CH_GREEN] = pixel.green;
    assign ch[rfs_pkg::CH_BLUE] = pixel.blue;

    always_comb
    begin
        mx = ch[rfs_pkg::CH_RED];
        mn = ch[rfs_pkg::CH_RED];
        if (ch[rfs_pkg::CH_GREEN] > mx)
        begin
            mx = ch[rfs_pkg::CH_GREEN];
        end
        if (ch[rfs_pkg::CH_BLUE] > mx)
        begin
            mx = ch[rfs_pkg::CH_BLUE];
        end
        if (ch[rfs_pkg::CH_GREEN] < mn)
        begin
            mn = ch[rfs_pkg::CH_GREEN];
        end
        if (ch[rfs_pkg::CH_BLUE] < mn)
        begin
            mn = ch[rfs_pkg::CH_BLUE];
        end

        range_next.valid = valid;
        range_next.d = mx - mn;
        range_next.flat = (mx == mn);
        mid_val = '0;
        for (int i = 0; i < rfs_pkg::NUM_CH; i++)
        begin
            range_next.top[i] = (ch[i] == mx);
            range_next.bot[i] = (ch[i] == mn);
            edge_mask[i] = range_next.top[i] | range_next.bot[i];
            if (!edge_mask[i])
            begin
                mid_val = mid_val | ch[i];
            end
        end
        // At most one channel lies strictly between the extremes.
        range_next.n = (&edge_mask) ? '0 : (mid_val - mn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            range_reg <= range_next;
        end
    end

    // The dividend is full scale times the middle offset, split so that the
    // upper part is already below the divisor.
    always_comb
    begin
        fn = (rfs_pkg::prod_t'(range_reg.n) << rfs_pkg::CHANNEL_BITS)
             - rfs_pkg::prod_t'(range_reg.n);
        div_next.valid = range_reg.valid;
        div_next.flat = range_reg.flat;
        div_next.top = range_reg.top;
        div_next.bot = range_reg.bot;
        div_next.d = range_reg.d;
        div_next.rem = rfs_pkg::chan_t'(fn >> rfs_pkg::DIV_BITS);
        div_next.low = fn[rfs_pkg::DIV_BITS-1:0];
        div_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

[sv/rfs_div_stage.sv]
// One registered stage of the restoring divider, two quotient bits per stage.
module rfs_div_stage (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  rfs_pkg::divst_t stage_in,
    output rfs_pkg::divst_t stage_out
);

    rfs_pkg::divst_t stage_next;
    rfs_pkg::divst_t stage_reg;

    always_comb
    begin
        logic [rfs_pkg::CHANNEL_BITS:0] t;
        logic qbit;
        stage_next = stage_in;
        for (int j = 0; j < rfs_pkg::DIV_STEPS_PER_STAGE; j++)
        begin
            t = {stage_next.rem, stage_next.low[rfs_pkg::DIV_BITS-1]};
            qbit = (t >= {1'b0, stage_next.d});
            if (qbit)
            begin
                t = t - {1'b0, stage_next.d};
            end
            stage_next.rem = t[rfs_pkg::CHANNEL_BITS-1:0];
            stage_next.low = stage_next.low << 1;
            stage_next.quo = {stage_next.quo[rfs_pkg::DIV_BITS-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

[sv/rfs_round.sv]
// Back end: rounds the quotient and assembles the output word.
module rfs_round (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  rfs_pkg::divst_t div_in,
    output logic valid,
    output rfs_pkg::pixel_t pixel
);

    rfs_pkg::chan_t qr;
    rfs_pkg::chan_t res [rfs_pkg::NUM_CH];
    logic valid_reg;
    rfs_pkg::pixel_t pixel_next;
    rfs_pkg::pixel_t pixel_reg;

    always_comb
    begin
        // Round half up: the remainder is at least half the divisor.
        qr = rfs_pkg::chan_t'(div_in.quo)
             + rfs_pkg::chan_t'({div_in.rem, 1'b0} >= {1'b0, div_in.d});
        for (int i = 0; i < rfs_pkg::NUM_CH; i++)
        begin
            if (div_in.flat)
            begin
                res[i] = (i == rfs_pkg::CH_RED) ? rfs_pkg::FULL_SCALE : '0;
            end
            else if (div_in.top[i])
            begin
                res[i] = rfs_pkg::FULL_SCALE;
            end
            else if (div_in.bot[i])
            begin
                res[i] = '0;
            end
            else
            begin
                res[i] = qr;
            end
        end
        pixel_next.red = res[rfs_pkg::CH_RED];
        pixel_next.green = res[rfs_pkg::CH_GREEN];
        pixel_next.blue = res[rfs_pkg::CH_BLUE];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= div_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign valid = valid_reg;
    assign pixel = pixel_reg;

endmodule

[sv/rgb_full_saturate_unit.sv]
// Top level of the full-saturation pixel pipeline.
//
//   port    | direction | word
//   --------+-----------+--------------------------------------
//   pixel   | sink      | red_in, green_in, blue_in
//   result  | source    | red_out, green_out, blue_out
//
// One pixel enters in every cycle unless the output stalls; the restoring divider
// retires two quotient bits per stage.
// Reset clears only the valid bits of the stages; the pipeline then starts empty.
// When the output register holds a word that is not taken, the whole pipeline
// holds and pixel.ready is low; nothing is lost or repeated.
`include "assert_macros.svh"

module rgb_full_saturate_unit (
    input  logic clk,
    input  logic rst_n,
    rfs_pixel_in_if.sink pixel,
    rfs_pixel_out_if.source result
);

    logic adv;
    rfs_pkg::pixel_t pix_in;
    rfs_pkg::pixel_t pix_out;
    rfs_pkg::divst_t chain [rfs_pkg::DIV_STAGES+1];

    assign adv = !result.valid || result.ready;
    assign pixel.ready = adv;

    assign pix_in.red = pixel.red_in;
    assign pix_in.green = pixel.green_in;
    assign pix_in.blue = pixel.blue_in;

    rfs_range u_range (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .valid   (pixel.valid),
        .pixel   (pix_in),
        .div_out (chain[0])
    );

    for (genvar s = 0; s < rfs_pkg::DIV_STAGES; s++)
    begin : g_div
        rfs_div_stage u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .stage_in  (chain[s]),
            .stage_out (chain[s+1])
        );
    end

    rfs_round u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .div_in (chain[rfs_pkg::DIV_STAGES]),
        .valid  (result.valid),
        .pixel  (pix_out)
    );

    assign result.red_out = pix_out.red;
    assign result.green_out = pix_out.green;
    assign result.blue_out = pix_out.blue;

    // Every result has one channel at full scale and one at zero.
    `ASSERT_SAME(a_has_full, clk, rst_n, result.valid, (result.red_out == rfs_pkg::FULL_SCALE) || (result.green_out == rfs_pkg::FULL_SCALE) || (result.blue_out == rfs_pkg::FULL_SCALE), "result has no full-scale channel")
    `ASSERT_SAME(a_has_zero, clk, rst_n, result.valid, (result.red_out == '0) || (result.green_out == '0) || (result.blue_out == '0), "result has no zero channel")
    // The final remainder of a real division stays below the divisor.
    `ASSERT_SAME(a_rem_bound, clk, rst_n, chain[rfs_pkg::DIV_STAGES].valid && !chain[rfs_pkg::DIV_STAGES].flat, chain[rfs_pkg::DIV_STAGES].rem < chain[rfs_pkg::DIV_STAGES].d, "divider remainder out of range")
    `ASSERT_SAME(a_stall_blocks, clk, rst_n, result.valid && !result.ready, !pixel.ready, "input taken while output stalled")
    `ASSERT_NEXT(a_stall_holds, clk, rst_n, !adv, $stable(chain[rfs_pkg::DIV_STAGES]), "divider moved during a stall")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the full-saturation pixel pipeline.
module tb_top;

    localparam int PIPE_LATENCY = 3 + rfs_pkg::DIV_STAGES;
    localparam int MAX_REPORTS = 40;

    logic clk;
    logic rst_n;

    rfs_pixel_in_if pixel_if ();
    rfs_pixel_out_if result_if ();

    rgb_full_saturate_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .pixel(pixel_if),
        .result(result_if)
    );

    rfs_pkg::pixel_t pending_pixels[$];
    rfs_pkg::pixel_t expected_pixels[$];
    int unsigned driven_count = 0;
    int unsigned accepted_count = 0;
    int unsigned results_seen = 0;
    int unsigned error_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic rfs_pkg::chan_t scale_channel(input longint unsigned c,
                                                     input longint unsigned lo,
                                                     input longint unsigned span);
        longint unsigned full;
        full = rfs_pkg::FULL_SCALE;
        return rfs_pkg::chan_t'((2 * full * (c - lo) + span) / (2 * span));
    endfunction

    // Largest channel goes to full scale, smallest to zero, middle scaled and rounded.
    function automatic rfs_pkg::pixel_t saturate_pixel(input rfs_pkg::pixel_t px);
        longint unsigned hi;
        longint unsigned lo;
        rfs_pkg::pixel_t res;
        hi = px.red;
        lo = px.red;
        if (px.green > hi) hi = px.green;
        if (px.blue > hi) hi = px.blue;
        if (px.green < lo) lo = px.green;
        if (px.blue < lo) lo = px.blue;
        if (hi == lo)
        begin
            // Black and gray have no hue and come out as pure red.
            res.red = rfs_pkg::FULL_SCALE;
            res.green = '0;
            res.blue = '0;
        end
        else
        begin
            res.red = scale_channel(px.red, lo, hi - lo);
            res.green = scale_channel(px.green, lo, hi - lo);
            res.blue = scale_channel(px.blue, lo, hi - lo);
        end
        return res;
    endfunction

    function automatic rfs_pkg::chan_t near_channel(input rfs_pkg::chan_t base);
        int unsigned v;
        v = base + $urandom_range(0, 3);
        if (v > rfs_pkg::FULL_SCALE) v = rfs_pkg::FULL_SCALE;
        return rfs_pkg::chan_t'(v);
    endfunction

    function automatic rfs_pkg::pixel_t random_pixel();
        rfs_pkg::pixel_t px;
        rfs_pkg::chan_t base;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        base = rfs_pkg::chan_t'($urandom);
        px.red = rfs_pkg::chan_t'($urandom);
        px.green = rfs_pkg::chan_t'($urandom);
        px.blue = rfs_pkg::chan_t'($urandom);
        case (sel)
            6:
            begin
                // Nearly gray: a small spread stresses the divider and rounding.
                px.red = near_channel(base);
                px.green = near_channel(base);
                px.blue = near_channel(base);
            end
            7:
            begin
                case ($urandom_range(0, 2))
                    0: px.green = px.red;
                    1: px.blue = px.green;
                    default: px.red = px.blue;
                endcase
            end
            8:
            begin
                px.red = base;
                px.green = base;
                px.blue = base;
            end
            9:
            begin
                px.red = $urandom_range(0, 1) ? rfs_pkg::FULL_SCALE : '0;
                px.blue = $urandom_range(0, 1) ? rfs_pkg::FULL_SCALE : '0;
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic queue_pixel(input int unsigned r, input int unsigned g, input int unsigned b);
        rfs_pkg::pixel_t px;
        px.red = rfs_pkg::chan_t'(r);
        px.green = rfs_pkg::chan_t'(g);
        px.blue = rfs_pkg::chan_t'(b);
        pending_pixels.push_back(px);
    endtask

    // Sender: a new word goes up only after the previous one was taken.
    always @(negedge clk)
    begin : pixel_driver
        rfs_pkg::pixel_t px;
        logic next_valid;
        if (rst_n)
        begin
            next_valid = pixel_if.valid;
            if (driven_count == accepted_count)
            begin
                next_valid = 1'b0;
                if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    px = pending_pixels.pop_front();
                    pixel_if.red_in <= px.red;
                    pixel_if.green_in <= px.green;
                    pixel_if.blue_in <= px.blue;
                    driven_count++;
                    next_valid = 1'b1;
                end
            end
            pixel_if.valid <= next_valid;
            result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : pixel_monitor
        rfs_pkg::pixel_t px;
        rfs_pkg::pixel_t want;
        if (rst_n)
        begin
            if (pixel_if.valid && pixel_if.ready)
            begin
                px.red = pixel_if.red_in;
                px.green = pixel_if.green_in;
                px.blue = pixel_if.blue_in;
                expected_pixels.push_back(saturate_pixel(px));
                accepted_count++;
            end
            if (result_if.valid && result_if.ready)
            begin
                results_seen++;
                if (expected_pixels.size() == 0)
                    report("result word with no pixel outstanding");
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result_if.red_out !== want.red)
                        report($sformatf("red_out %0d, expected %0d",
                                         result_if.red_out, want.red));
                    if (result_if.green_out !== want.green)
                        report($sformatf("green_out %0d, expected %0d",
                                         result_if.green_out, want.green));
                    if (result_if.blue_out !== want.blue)
                        report($sformatf("blue_out %0d, expected %0d",
                                         result_if.blue_out, want.blue));
                end
            end
        end
    end

    // Feeds one phase, then waits until every result is back.
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) pending_pixels.push_back(random_pixel());
        while (pending_pixels.size() != 0 || driven_count != accepted_count ||
               expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        pixel_if.valid = 1'b0;
        pixel_if.red_in = '0;
        pixel_if.green_in = '0;
        pixel_if.blue_in = '0;
        result_if.ready = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        queue_pixel(0, 0, 0);
        queue_pixel(1, 1, 1);
        queue_pixel(128, 128, 128);
        queue_pixel(255, 255, 255);
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 255, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 255);
        queue_pixel(200, 10, 10);
        queue_pixel(10, 200, 10);
        queue_pixel(10, 10, 200);
        queue_pixel(0, 1, 2);
        queue_pixel(1, 0, 0);
        queue_pixel(0, 1, 1);
        queue_pixel(255, 254, 0);
        queue_pixel(1, 0, 255);
        queue_pixel(254, 255, 253);
        queue_pixel(100, 50, 150);
        queue_pixel(255, 128, 0);
        queue_pixel(3, 1, 2);
        queue_pixel(170, 85, 0);

        run_phase(0, 0, 500);
        run_phase(65, 0, 500);
        run_phase(0, 65, 500);
        run_phase(19, 19, 500);

        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (expected_pixels.size() != 0)
            report("pixels accepted without a result");

        $display("Sent %0d pixels and checked %0d results: black, gray, tied channels,",
                 accepted_count, results_seen);
        $display("half-way rounding and random pixels under sender gaps and receiver stalls.");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", expected_pixels.size());
        $display("Some tests failed");
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/rfs_pkg.sv
sv/rfs_channels.sv
sv/rfs_range.sv
sv/rfs_div_stage.sv
sv/rfs_round.sv
sv/rgb_full_saturate_unit.sv
tb/tb_top.sv
